// ===== src/rna_pkg.sv =====
// rna_pkg: shared types, codes and the micro-program table of the rational alu
// no dependencies; used by rna_ctrl, rna_dp and rational_number_alu_top
`timescale 1ns / 1ps

package rna_pkg;

    localparam int DEF_WIDTH = 32;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_CMP = 3'd4,
        ACT_RED = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        UOP_NORM,
        UOP_MUL,
        UOP_ADD,
        UOP_CMP,
        UOP_END
    } t_uop_op;

    typedef enum logic [2:0] {
        REG_LN,
        REG_LD,
        REG_RN,
        REG_RD,
        REG_T0,
        REG_T1
    } t_reg_sel;

    typedef struct packed {
        t_uop_op  op;
        t_reg_sel src_a;
        t_reg_sel src_b;
        t_reg_sel dst_a;
        t_reg_sel dst_b;
    } t_uop;

    typedef struct packed {
        logic load;
        logic start;
        logic emit;
        t_uop uop;
    } t_ctl_cmd;

    typedef struct packed {
        logic done;
    } t_dp_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_FINISH
    } t_ctl_state;

    typedef enum logic [2:0] {
        DP_IDLE,
        DP_SHIFT,
        DP_GCD,
        DP_DIV,
        DP_MUL
    } t_dp_phase;

    function automatic t_uop mk_uop(t_uop_op op, t_reg_sel sa, t_reg_sel sb,
                                    t_reg_sel da, t_reg_sel db);
        t_uop u;
        u.op    = op;
        u.src_a = sa;
        u.src_b = sb;
        u.dst_a = da;
        u.dst_b = db;
        return u;
    endfunction

    // micro-program per action; every program starts by reducing both operands
    function automatic t_uop uop_rom(logic [2:0] act, logic [3:0] step);
        t_uop u;
        u = mk_uop(UOP_END, REG_LN, REG_LD, REG_LN, REG_LD);
        if (step == 4'd0) begin
            u = mk_uop(UOP_NORM, REG_LN, REG_LD, REG_LN, REG_LD);
        end else if (step == 4'd1) begin
            u = mk_uop(UOP_NORM, REG_RN, REG_RD, REG_RN, REG_RD);
        end else begin
            unique case (act) inside
                ACT_ADD, ACT_SUB: begin
                    case (step)
                        4'd2: u = mk_uop(UOP_NORM, REG_LD, REG_RD, REG_T0, REG_T1);
                        4'd3: u = mk_uop(UOP_MUL, REG_LN, REG_T1, REG_LN, REG_LN);
                        4'd4: u = mk_uop(UOP_MUL, REG_RN, REG_T0, REG_RN, REG_RN);
                        4'd5: u = mk_uop(UOP_MUL, REG_LD, REG_T1, REG_LD, REG_LD);
                        4'd6: u = mk_uop(UOP_ADD, REG_LN, REG_RN, REG_LN, REG_LN);
                        4'd7: u = mk_uop(UOP_NORM, REG_LN, REG_LD, REG_LN, REG_LD);
                        default: ;
                    endcase
                end
                ACT_MUL: begin
                    case (step)
                        4'd2: u = mk_uop(UOP_NORM, REG_RN, REG_LD, REG_RN, REG_LD);
                        4'd3: u = mk_uop(UOP_NORM, REG_LN, REG_RD, REG_LN, REG_RD);
                        4'd4: u = mk_uop(UOP_MUL, REG_RN, REG_LN, REG_LN, REG_LN);
                        4'd5: u = mk_uop(UOP_MUL, REG_LD, REG_RD, REG_LD, REG_LD);
                        default: ;
                    endcase
                end
                ACT_DIV: begin
                    case (step)
                        4'd2: u = mk_uop(UOP_NORM, REG_RD, REG_RN, REG_RD, REG_RN);
                        4'd3: u = mk_uop(UOP_NORM, REG_RD, REG_LD, REG_RD, REG_LD);
                        4'd4: u = mk_uop(UOP_NORM, REG_LN, REG_RN, REG_LN, REG_RN);
                        4'd5: u = mk_uop(UOP_MUL, REG_RD, REG_LN, REG_LN, REG_LN);
                        4'd6: u = mk_uop(UOP_MUL, REG_LD, REG_RN, REG_LD, REG_LD);
                        default: ;
                    endcase
                end
                ACT_CMP: begin
                    case (step)
                        4'd2: u = mk_uop(UOP_MUL, REG_LN, REG_RD, REG_T0, REG_T0);
                        4'd3: u = mk_uop(UOP_MUL, REG_LD, REG_RN, REG_T1, REG_T1);
                        4'd4: u = mk_uop(UOP_CMP, REG_T0, REG_T1, REG_T0, REG_T1);
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        return u;
    endfunction

endpackage

// ===== src/rational_number_alu_top.sv =====
// rational_number_alu_top: fraction add/sub/mul/div/compare/reduce with stream ports
// depends on rna_pkg, rna_ctrl and rna_dp
// a reduction is a binary gcd of both parts, then two one-bit-per-cycle divisions of the
//   numerator and the denominator by that gcd; a product is a shift-add over WIDTH bits
// one item at a time; add/sub run four reductions, three products and one add
// reset: synchronous active-low i_rst_n clears the sequencer and the output valid
`timescale 1ns / 1ps

module rational_number_alu_top import rna_pkg::*; #(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input items
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // left_num, left_den, right_num, right_den from bit 0 up, zero padded to bytes
    input  logic [((4*WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // action
    input  logic [2:0]          s_axis_tuser,
    // result items
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // res_num, res_den from bit 0 up, zero padded to bytes
    output logic [((2*WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // less, greater, equal, overflow from bit 0 up
    output logic [3:0]          m_axis_tuser
);

    localparam int DOUT_W = ((2*WIDTH+7)/8)*8;

    t_ctl_cmd   w_cmd;
    t_dp_status w_status;
    logic       w_out_free;

    logic signed [WIDTH-1:0] w_res_num, w_res_den;
    logic w_less, w_greater, w_equal, w_overflow;

    // output register: holds a finished item while the next one is worked on
    logic              r_out_valid;
    logic [DOUT_W-1:0] r_out_data;
    logic [3:0]        r_out_user;

    assign w_out_free = !r_out_valid || m_axis_tready;

    rna_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_action   (s_axis_tuser),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rna_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_action    (s_axis_tuser),
        .i_left_num  ($signed(s_axis_tdata[WIDTH-1:0])),
        .i_left_den  ($signed(s_axis_tdata[2*WIDTH-1:WIDTH])),
        .i_right_num ($signed(s_axis_tdata[3*WIDTH-1:2*WIDTH])),
        .i_right_den ($signed(s_axis_tdata[4*WIDTH-1:3*WIDTH])),
        .o_status    (w_status),
        .o_res_num   (w_res_num),
        .o_res_den   (w_res_den),
        .o_less      (w_less),
        .o_greater   (w_greater),
        .o_equal     (w_equal),
        .o_overflow  (w_overflow)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_cmd.emit) begin
            r_out_data <= DOUT_W'({w_res_den, w_res_num});
            r_out_user <= {w_overflow, w_equal, w_greater, w_less};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

// ===== src/rna_ctrl.sv =====
// rna_ctrl: sequencer that walks the micro-program of one item
// depends on rna_pkg
`timescale 1ns / 1ps

module rna_ctrl import rna_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_action,
    input  logic       i_out_free,
    input  t_dp_status i_status,
    output t_ctl_cmd   o_cmd
);

    t_ctl_state r_state, n_state;
    logic [3:0] r_step, n_step;
    logic [2:0] r_action, n_action;
    t_uop       w_uop;

    assign w_uop = uop_rom(r_action, r_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_action <= '0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_action <= n_action;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_action   = r_action;
        o_in_ready = 1'b0;
        o_cmd.load  = 1'b0;
        o_cmd.start = 1'b0;
        o_cmd.emit  = 1'b0;
        o_cmd.uop   = w_uop;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_action   = i_action;
                    n_state    = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (w_uop.op == UOP_END) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (i_status.done) begin
                    n_step  = r_step + 4'd1;
                    n_state = ST_ISSUE;
                end
            end
            ST_FINISH: begin
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== src/rna_dp.sv =====
// rna_dp: operand registers, gcd reducer, restoring divider, shift-add multiplier
// depends on rna_pkg; driven by rna_ctrl commands
`timescale 1ns / 1ps

module rna_dp import rna_pkg::*; #(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl_cmd                i_cmd,
    input  logic [2:0]              i_action,
    input  logic signed [WIDTH-1:0] i_left_num,
    input  logic signed [WIDTH-1:0] i_left_den,
    input  logic signed [WIDTH-1:0] i_right_num,
    input  logic signed [WIDTH-1:0] i_right_den,
    output t_dp_status              o_status,
    output logic signed [WIDTH-1:0] o_res_num,
    output logic signed [WIDTH-1:0] o_res_den,
    output logic                    o_less,
    output logic                    o_greater,
    output logic                    o_equal,
    output logic                    o_overflow
);

    localparam int MW = 2*WIDTH + 2;
    localparam int CW = $clog2(MW + 1);

    typedef struct packed {
        logic          neg;
        logic [MW-1:0] mag;
    } t_val;

    localparam t_val V_ZERO = '{neg: 1'b0, mag: '0};
    localparam t_val V_ONE  = '{neg: 1'b0, mag: MW'(1)};

    function automatic t_val from_field(logic [WIDTH-1:0] f, logic flip);
        t_val v;
        logic [WIDTH-1:0] m;
        m     = f[WIDTH-1] ? (~f + 1'b1) : f;
        v.mag = {{(MW-WIDTH){1'b0}}, m};
        v.neg = flip ? (!f[WIDTH-1] && (f != '0)) : f[WIDTH-1];
        return v;
    endfunction

    function automatic logic fits(t_val v);
        logic hi_zero;
        hi_zero = (v.mag[MW-1:WIDTH] == '0);
        return hi_zero && (v.neg ? (v.mag[WIDTH-1:0] <= {1'b1, {(WIDTH-1){1'b0}}})
                                 : !v.mag[WIDTH-1]);
    endfunction

    function automatic logic [WIDTH-1:0] to_field(t_val v);
        logic [WIDTH-1:0] m;
        m = v.mag[WIDTH-1:0];
        return v.neg ? (~m + 1'b1) : m;
    endfunction

    t_val r_ln, r_ld, r_rn, r_rd, r_t0, r_t1;
    logic [2:0] r_action;
    t_dp_phase  r_phase;
    logic [MW-1:0] r_wa, r_wb, r_nn, r_dd, r_g, r_q, r_rem;
    logic [CW-1:0] r_cnt;
    logic r_sa, r_sb, r_second, r_done;
    logic r_lt, r_gt;
    t_reg_sel r_dst_a, r_dst_b;

    t_val v_a, v_b;
    t_val w_a_val, w_b_val, w_sum;
    logic w_a_en, w_b_en;
    t_reg_sel w_a_sel, w_b_sel;
    logic w_dz, w_eqm, w_nz, w_special;
    logic [MW:0] w_t;
    logic w_ge;
    logic [MW-1:0] w_rem_n, w_q_n;
    logic w_arith, w_ovf;

    // operand selection
    always_comb begin
        unique case (i_cmd.uop.src_a)
            REG_LN: v_a = r_ln;
            REG_LD: v_a = r_ld;
            REG_RN: v_a = r_rn;
            REG_RD: v_a = r_rd;
            REG_T0: v_a = r_t0;
            REG_T1: v_a = r_t1;
            default: v_a = V_ZERO;
        endcase
        unique case (i_cmd.uop.src_b)
            REG_LN: v_b = r_ln;
            REG_LD: v_b = r_ld;
            REG_RN: v_b = r_rn;
            REG_RD: v_b = r_rd;
            REG_T0: v_b = r_t0;
            REG_T1: v_b = r_t1;
            default: v_b = V_ZERO;
        endcase
    end

    // reduction shortcuts and sign-magnitude add
    assign w_dz      = (v_b.mag == '0);
    assign w_eqm     = (v_a.mag == v_b.mag);
    assign w_nz      = (v_a.mag == '0);
    assign w_special = w_dz || w_eqm || w_nz;

    always_comb begin
        if (v_a.neg == v_b.neg) begin
            w_sum.mag = v_a.mag + v_b.mag;
            w_sum.neg = v_a.neg;
        end else if (v_a.mag >= v_b.mag) begin
            w_sum.mag = v_a.mag - v_b.mag;
            w_sum.neg = v_a.neg;
        end else begin
            w_sum.mag = v_b.mag - v_a.mag;
            w_sum.neg = v_b.neg;
        end
        if (w_sum.mag == '0) begin
            w_sum.neg = 1'b0;
        end
    end

    // one restoring division step
    assign w_t     = {r_rem, r_q[MW-1]};
    assign w_ge    = (w_t >= {1'b0, r_g});
    assign w_rem_n = w_ge ? MW'(w_t - {1'b0, r_g}) : w_t[MW-1:0];
    assign w_q_n   = {r_q[MW-2:0], w_ge};

    // write-back ports
    always_comb begin
        w_a_en  = 1'b0;
        w_b_en  = 1'b0;
        w_a_sel = r_dst_a;
        w_b_sel = r_dst_b;
        w_a_val = V_ZERO;
        w_b_val = V_ONE;
        unique case (r_phase)
            DP_IDLE: begin
                w_a_sel = i_cmd.uop.dst_a;
                w_b_sel = i_cmd.uop.dst_b;
                if (i_cmd.start) begin
                    case (i_cmd.uop.op)
                        UOP_NORM: begin
                            if (w_special) begin
                                w_a_en = 1'b1;
                                w_b_en = 1'b1;
                                if (!w_dz && w_eqm) begin
                                    w_a_val.neg = v_a.neg ^ v_b.neg;
                                    w_a_val.mag = MW'(1);
                                end
                            end
                        end
                        UOP_ADD: begin
                            w_a_en  = 1'b1;
                            w_a_val = w_sum;
                        end
                        default: ;
                    endcase
                end
            end
            DP_DIV: begin
                if (r_cnt == CW'(MW)) begin
                    if (!r_second) begin
                        w_a_en  = 1'b1;
                        w_a_val = '{neg: r_sa, mag: r_q};
                    end else begin
                        w_b_en  = 1'b1;
                        w_b_val = '{neg: r_sb, mag: r_q};
                    end
                end
            end
            DP_MUL: begin
                if (r_cnt == CW'(WIDTH)) begin
                    w_a_en  = 1'b1;
                    w_a_val = '{neg: r_sa && (r_nn != '0), mag: r_nn};
                end
            end
            default: ;
        endcase
    end

    // operand registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_ln     <= from_field(i_left_num, 1'b0);
            r_ld     <= from_field(i_left_den, 1'b0);
            r_rn     <= from_field(i_right_num, i_action == ACT_SUB);
            r_rd     <= from_field(i_right_den, 1'b0);
        end else begin
            if (w_a_en) begin
                unique case (w_a_sel)
                    REG_LN: r_ln <= w_a_val;
                    REG_LD: r_ld <= w_a_val;
                    REG_RN: r_rn <= w_a_val;
                    REG_RD: r_rd <= w_a_val;
                    REG_T0: r_t0 <= w_a_val;
                    REG_T1: r_t1 <= w_a_val;
                    default: ;
                endcase
            end
            if (w_b_en) begin
                unique case (w_b_sel)
                    REG_LN: r_ln <= w_b_val;
                    REG_LD: r_ld <= w_b_val;
                    REG_RN: r_rn <= w_b_val;
                    REG_RD: r_rd <= w_b_val;
                    REG_T0: r_t0 <= w_b_val;
                    REG_T1: r_t1 <= w_b_val;
                    default: ;
                endcase
            end
        end
    end

    // unit sequencing: gcd, division, multiplication
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= DP_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                DP_IDLE: begin
                    if (i_cmd.start) begin
                        r_dst_a <= i_cmd.uop.dst_a;
                        r_dst_b <= i_cmd.uop.dst_b;
                        case (i_cmd.uop.op)
                            UOP_NORM: begin
                                if (w_special) begin
                                    r_done <= 1'b1;
                                end else begin
                                    r_wa    <= v_a.mag;
                                    r_wb    <= v_b.mag;
                                    r_sa    <= v_a.neg;
                                    r_sb    <= v_b.neg;
                                    r_phase <= DP_SHIFT;
                                end
                            end
                            UOP_MUL: begin
                                r_wa    <= {{(MW-WIDTH){1'b0}}, v_a.mag[WIDTH-1:0]};
                                r_wb    <= v_b.mag;
                                r_nn    <= '0;
                                r_cnt   <= '0;
                                r_sa    <= v_a.neg ^ v_b.neg;
                                r_phase <= DP_MUL;
                            end
                            UOP_CMP: begin
                                if (r_t0.neg != r_t1.neg) begin
                                    r_lt <= r_t0.neg;
                                    r_gt <= !r_t0.neg;
                                end else begin
                                    r_lt <= r_t0.neg ? (r_t0.mag > r_t1.mag)
                                                     : (r_t0.mag < r_t1.mag);
                                    r_gt <= r_t0.neg ? (r_t0.mag < r_t1.mag)
                                                     : (r_t0.mag > r_t1.mag);
                                end
                                r_done <= 1'b1;
                            end
                            default: r_done <= 1'b1;
                        endcase
                    end
                end
                DP_SHIFT: begin
                    // strip common factors of two, keep the shifted parts
                    if (!r_wa[0] && !r_wb[0]) begin
                        r_wa <= r_wa >> 1;
                        r_wb <= r_wb >> 1;
                    end else begin
                        r_nn    <= r_wa;
                        r_dd    <= r_wb;
                        r_phase <= DP_GCD;
                    end
                end
                DP_GCD: begin
                    if (r_wa == '0 || r_wb == '0) begin
                        r_g      <= (r_wa == '0) ? r_wb : r_wa;
                        r_q      <= r_nn;
                        r_rem    <= '0;
                        r_cnt    <= '0;
                        r_second <= 1'b0;
                        r_phase  <= DP_DIV;
                    end else if (!r_wa[0]) begin
                        r_wa <= r_wa >> 1;
                    end else if (!r_wb[0]) begin
                        r_wb <= r_wb >> 1;
                    end else if (r_wa >= r_wb) begin
                        r_wa <= r_wa - r_wb;
                    end else begin
                        r_wb <= r_wb - r_wa;
                    end
                end
                DP_DIV: begin
                    if (r_cnt == CW'(MW)) begin
                        if (!r_second) begin
                            r_q      <= r_dd;
                            r_rem    <= '0;
                            r_cnt    <= '0;
                            r_second <= 1'b1;
                        end else begin
                            r_phase <= DP_IDLE;
                            r_done  <= 1'b1;
                        end
                    end else begin
                        r_q   <= w_q_n;
                        r_rem <= w_rem_n;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                DP_MUL: begin
                    if (r_cnt == CW'(WIDTH)) begin
                        r_phase <= DP_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        if (r_wb[0]) begin
                            r_nn <= r_nn + r_wa;
                        end
                        r_wa  <= r_wa << 1;
                        r_wb  <= r_wb >> 1;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: r_phase <= DP_IDLE;
            endcase
        end
    end

    assign o_status.done = r_done;

    // result shaping
    assign w_arith = (r_action == ACT_ADD) || (r_action == ACT_SUB) ||
                     (r_action == ACT_MUL) || (r_action == ACT_DIV) ||
                     (r_action == ACT_RED);
    assign w_ovf   = w_arith && !(fits(r_ln) && fits(r_ld));

    assign o_res_num  = (w_arith && !w_ovf) ? to_field(r_ln) : '0;
    assign o_res_den  = (w_arith && !w_ovf) ? to_field(r_ld) : WIDTH'(1);
    assign o_overflow = w_ovf;
    assign o_less     = (r_action == ACT_CMP) && r_lt;
    assign o_greater  = (r_action == ACT_CMP) && r_gt;
    assign o_equal    = (r_action == ACT_CMP) && (r_ln == r_rn) && (r_ld == r_rd);

endmodule
